[hw/rtl/e2q_pkg.sv]
// Shared types, constants and rounding helper for the Euler-to-quaternion pipeline.
package e2q_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int WORK_FRAC    = 30;
  localparam int PHASE_W      = 32;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int NUM_TERMS    = 8;
  localparam int NUM_COMP     = 4;
  localparam int QUAT_W       = 16;
  localparam int OUT_W        = NUM_COMP * QUAT_W;

  // CORDIC gain in Q30
  localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // arctan(2^-i) in phase units, 2^32 per turn
  localparam logic signed [PHASE_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  typedef logic signed [DATA_W-1:0] q30_t;

  typedef struct packed {
    q30_t cosv;
    q30_t sinv;
  } cs_t;

  // Q60 product back to Q30, round half up
  function automatic q30_t round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) <<< (WORK_FRAC - 1));
    return t[WORK_FRAC+DATA_W-1:WORK_FRAC];
  endfunction

endpackage

[hw/rtl/e2q_cordic.sv]
// Fully pipelined rotation-mode CORDIC: half-angle cosine and sine, one stage per step.
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output cs_t                          cs_o
);

  localparam int ZShift = PHASE_W - 1 - ANGLE_BITS;

  // half angle: angle scaled so that 2^32 is one turn, then halved
  logic signed [PHASE_W-1:0] z_init;
  assign z_init = PHASE_W'(angle_i) <<< ZShift;

  q30_t                      x_q [CORDIC_STEPS];
  q30_t                      y_q [CORDIC_STEPS];
  logic signed [PHASE_W-1:0] z_q [CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    q30_t                      xi, yi, dx, dy;
    logic signed [PHASE_W-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_init;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[PHASE_W-1]) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
        end else begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
        end
      end
    end

    // residual phase is not needed after the last step
    if (i < CORDIC_STEPS - 1) begin : g_phase
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!zi[PHASE_W-1]) begin
            z_q[i] <= zi - ATAN_TABLE[i];
          end else begin
            z_q[i] <= zi + ATAN_TABLE[i];
          end
        end
      end
    end
  end

  assign cs_o.cosv = x_q[CORDIC_STEPS-1];
  assign cs_o.sinv = y_q[CORDIC_STEPS-1];

endmodule

[hw/rtl/e2q_mult.sv]
// Two-stage multiply tree: yaw*pitch pair products, then times the roll terms.
module e2q_mult
  import e2q_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  cs_t  roll_i,
  input  cs_t  pitch_i,
  input  cs_t  yaw_i,
  output q30_t term_o [NUM_TERMS]
);

  logic signed [PROD_W-1:0] p_cc, p_ss, p_sc, p_cs;
  q30_t cc_q, ss_q, sc_q, cs_q, cr_q, sr_q;

  assign p_cc = yaw_i.cosv * pitch_i.cosv;
  assign p_ss = yaw_i.sinv * pitch_i.sinv;
  assign p_sc = yaw_i.sinv * pitch_i.cosv;
  assign p_cs = yaw_i.cosv * pitch_i.sinv;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= round_q30(p_cc);
      ss_q <= round_q30(p_ss);
      sc_q <= round_q30(p_sc);
      cs_q <= round_q30(p_cs);
      cr_q <= roll_i.cosv;
      sr_q <= roll_i.sinv;
    end
  end

  // term order: cc*cr, ss*sr, cc*sr, ss*cr, sc*sr, cs*cr, sc*cr, cs*sr
  logic signed [PROD_W-1:0] p_t [NUM_TERMS];
  q30_t                     term_q [NUM_TERMS];

  assign p_t[0] = cc_q * cr_q;
  assign p_t[1] = ss_q * sr_q;
  assign p_t[2] = cc_q * sr_q;
  assign p_t[3] = ss_q * cr_q;
  assign p_t[4] = sc_q * sr_q;
  assign p_t[5] = cs_q * cr_q;
  assign p_t[6] = sc_q * cr_q;
  assign p_t[7] = cs_q * sr_q;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        term_q[k] <= round_q30(p_t[k]);
      end
    end
    assign term_o[k] = term_q[k];
  end

endmodule

[hw/rtl/e2q_out.sv]
// Output stage: pairs terms, rounds to the output fraction and saturates to +-1.0.
module e2q_out
  import e2q_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  q30_t              term_i [NUM_TERMS],
  output logic [QUAT_W-1:0] quat_o [NUM_COMP]
);

  localparam int SumW  = DATA_W + 2;
  localparam int Shift = WORK_FRAC - QUAT_FRAC_BITS;
  localparam logic signed [SumW-1:0] One  = SumW'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (Shift - 1);

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_comp
    logic signed [SumW-1:0] sum, rnd, sat;
    logic [QUAT_W-1:0]      q_q;

    // w and y add their terms, x and z subtract
    if (k % 2 == 0) begin : g_add
      assign sum = SumW'(term_i[2*k]) + SumW'(term_i[2*k+1]);
    end else begin : g_sub
      assign sum = SumW'(term_i[2*k]) - SumW'(term_i[2*k+1]);
    end

    assign rnd = (sum + Half) >>> Shift;

    always_comb begin
      if (rnd > One) begin
        sat = One;
      end else if (rnd < -One) begin
        sat = -One;
      end else begin
        sat = rnd;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q <= sat[QUAT_W-1:0];
      end
    end

    assign quat_o[k] = q_q;
  end

endmodule

[hw/rtl/euler_to_quaternion_top.sv]
// Top level: ZYX Euler angles to unit quaternion, streaming, fully pipelined.
// Throughput: one word per cycle while the output is not stalled; the 30 CORDIC
// stages, two multiply stages and the rounding stage all advance together under one enable.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; data regs are not reset.
module euler_to_quaternion_top
  import e2q_pkg::*;
#(
  parameter  int ANGLE_BITS     = 16,
  parameter  int QUAT_FRAC_BITS = 14,
  localparam int InW            = ((3 * ANGLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [InW-1:0]   s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle (low to high)
  // master side
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z (low to high)
);

  localparam int Lat = CORDIC_STEPS + 3;

  // one valid bit per register stage; last one marks the output word
  logic [Lat-1:0] vld_q;
  logic           en;

  // whole pipe moves when the output word is empty or being taken
  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // half-angle sine/cosine per axis
  cs_t cs_roll, cs_pitch, cs_yaw;

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (signed'(s_axis_tdata[0*ANGLE_BITS +: ANGLE_BITS])),
    .cs_o    (cs_roll)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (signed'(s_axis_tdata[1*ANGLE_BITS +: ANGLE_BITS])),
    .cs_o    (cs_pitch)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (signed'(s_axis_tdata[2*ANGLE_BITS +: ANGLE_BITS])),
    .cs_o    (cs_yaw)
  );

  // eight triple products, two stages
  q30_t term [NUM_TERMS];

  e2q_mult u_mult (
    .clk_i   (clk_i),
    .en_i    (en),
    .roll_i  (cs_roll),
    .pitch_i (cs_pitch),
    .yaw_i   (cs_yaw),
    .term_o  (term)
  );

  // pair, round, saturate
  logic [QUAT_W-1:0] quat [NUM_COMP];

  e2q_out #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_out (
    .clk_i  (clk_i),
    .en_i   (en),
    .term_i (term),
    .quat_o (quat)
  );

  assign m_axis_tdata = {quat[3], quat[2], quat[1], quat[0]};

  // a stall freezes the valid pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("valid pipe moved during stall");

  // an accepted word occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word lost at pipe entry");

  // back-pressure only when a finished word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

endmodule
